### rtl/core/jacs_pkg.sv
package jacs_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned OUT_BITS = 8;

  localparam logic [7:0] CENTRE_OUT = 8'd127;
  localparam logic [7:0] FULL_OUT   = 8'd254;
  localparam logic [7:0] ZERO_OUT   = 8'd0;

  // Register map of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DB_LEFT  = 3'd0,
    CFG_DB_RIGHT = 3'd1,
    CFG_EARLY_LX = 3'd2,
    CFG_EARLY_LY = 3'd3,
    CFG_EARLY_RX = 3'd4,
    CFG_EARLY_RY = 3'd5,
    CFG_INVERT   = 3'd6
  } cfg_idx_e;

  localparam logic [7:0] RST_DEADBAND = 8'd10;
  localparam logic [7:0] RST_EARLY    = 8'd30;
  localparam logic [3:0] RST_INVERT   = 4'd12;

  // Factory extents, lx, ly, rx, ry; further axes repeat the pattern
  localparam logic [15:0] RST_MIN [4] = '{16'd330, 16'd205, 16'd300, 16'd215};
  localparam logic [15:0] RST_MID [4] = '{16'd512, 16'd477, 16'd525, 16'd529};
  localparam logic [15:0] RST_MAX [4] = '{16'd830, 16'd635, 16'd780, 16'd730};

  typedef struct packed {
    logic       done;
    logic [7:0] res;
  } lane_out_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       done;
  } cal_stat_t;

  typedef struct packed {
    logic pending;
    logic report;
  } item_ctl_t;

endpackage

### rtl/core/jacs_lane.sv
module jacs_lane #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   take_i,
  input  logic [SAMPLE_BITS-1:0] v_i,
  input  logic [SAMPLE_BITS-1:0] min_i,
  input  logic [SAMPLE_BITS-1:0] mid_i,
  input  logic [SAMPLE_BITS-1:0] max_i,
  input  logic [7:0]             db_i,
  input  logic [7:0]             es_i,
  output jacs_pkg::lane_out_t    out_o
);
  import jacs_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int W  = SAMPLE_BITS + 3;
  localparam int NB = W + 6;
  localparam int CW = $clog2(NB);
  localparam logic [CW-1:0] LAST_CNT = CW'(NB - 1);

  typedef enum logic [2:0] {
    L_IDLE, L_HALF, L_CLASS, L_LOAD, L_DIV, L_FIX, L_DONE
  } lane_state_e;

  lane_state_e          state_q;
  logic [SB-1:0]        v_q, mn_q, md_q, mx_q;
  logic [7:0]           db_q, es_q;
  logic signed [W-1:0]  i_q, mid_q, top_q;
  logic signed [W-1:0]  num_q, den_q;
  logic                 fixed_q;
  logic [7:0]           res_q, olo_q;
  logic [NB-1:0]        quo_q;
  logic [W-1:0]         rem_q, dmag_q;
  logic                 neg_q;
  logic [CW-1:0]        cnt_q;

  // (a - b) / 2, truncated toward zero
  function automatic logic signed [W-1:0] half_diff(input logic [SB-1:0] a,
                                                     input logic [SB-1:0] b);
    logic signed [SB:0] d;
    logic signed [SB:0] h;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    h = (d + $signed({{SB{1'b0}}, d[SB]})) >>> 1;
    return $signed({{2{h[SB]}}, h});
  endfunction

  // classification of the halved sample
  logic signed [W-1:0] es_s, db_s, mpd, mmd, tme;
  logic signed [W-1:0] num_d, den_d;
  logic                fixed_d;
  logic [7:0]          fres_d, olo_d;

  always_comb begin
    es_s    = $signed({{(W-8){1'b0}}, es_q});
    db_s    = $signed({{(W-8){1'b0}}, db_q});
    mpd     = mid_q + db_s;
    mmd     = mid_q - db_s;
    tme     = top_q - es_s;
    num_d   = i_q;
    den_d   = mmd;
    olo_d   = ZERO_OUT;
    fixed_d = 1'b1;
    fres_d  = CENTRE_OUT;
    priority if (i_q < mpd && i_q > mmd) begin
      fres_d = CENTRE_OUT;
    end else if (i_q < mid_q) begin
      if (i_q > es_s) begin
        fixed_d = 1'b0;
      end else begin
        fres_d = ZERO_OUT;
      end
    end else begin
      if (i_q < tme) begin
        fixed_d = 1'b0;
        num_d   = i_q - mpd;
        den_d   = top_q - mpd;
        olo_d   = CENTRE_OUT;
      end else begin
        fres_d = FULL_OUT;
      end
    end
  end

  // operand preparation for the divider
  logic signed [W+6:0] prod;
  logic [W+6:0]        pmag;
  logic [W-1:0]        dmag_d;

  always_comb begin
    prod   = $signed({num_q, 7'b0}) - $signed({{7{num_q[W-1]}}, num_q});
    pmag   = prod[W+6] ? (~prod + 1'b1) : prod;
    dmag_d = den_q[W-1] ? (~den_q + 1'b1) : den_q;
  end

  // one quotient bit per cycle
  logic [W:0]   rem_sh;
  logic         ge;
  logic [W-1:0] rem_d;
  logic [7:0]   q8, res_fix;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NB-1]};
    ge      = rem_sh >= {1'b0, dmag_q};
    rem_d   = ge ? W'(rem_sh - {1'b0, dmag_q}) : rem_sh[W-1:0];
    q8      = quo_q[7:0];
    res_fix = (neg_q ? (~q8 + 8'd1) : q8) + olo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      v_q     <= '0;
      mn_q    <= '0;
      md_q    <= '0;
      mx_q    <= '0;
      db_q    <= '0;
      es_q    <= '0;
      i_q     <= '0;
      mid_q   <= '0;
      top_q   <= '0;
      num_q   <= '0;
      den_q   <= '0;
      fixed_q <= 1'b0;
      res_q   <= '0;
      olo_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dmag_q  <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            v_q     <= v_i;
            mn_q    <= min_i;
            md_q    <= mid_i;
            mx_q    <= max_i;
            db_q    <= db_i;
            es_q    <= es_i;
            state_q <= L_HALF;
          end
        end
        L_HALF: begin
          i_q     <= half_diff(v_q, mn_q);
          mid_q   <= half_diff(md_q, mn_q);
          top_q   <= half_diff(mx_q, mn_q);
          state_q <= L_CLASS;
        end
        L_CLASS: begin
          num_q   <= num_d;
          den_q   <= den_d;
          olo_q   <= olo_d;
          fixed_q <= fixed_d;
          res_q   <= fres_d;
          state_q <= L_LOAD;
        end
        L_LOAD: begin
          if (fixed_q) begin
            state_q <= L_DONE;
          end else if (den_q == '0) begin
            res_q   <= CENTRE_OUT;
            state_q <= L_DONE;
          end else begin
            quo_q   <= pmag[NB-1:0];
            rem_q   <= '0;
            dmag_q  <= dmag_d;
            neg_q   <= prod[W+6] ^ den_q[W-1];
            cnt_q   <= LAST_CNT;
            state_q <= L_DIV;
          end
        end
        L_DIV: begin
          rem_q <= rem_d;
          quo_q <= {quo_q[NB-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= L_FIX;
          end
        end
        L_FIX: begin
          res_q   <= res_fix;
          state_q <= L_DONE;
        end
        L_DONE: begin
          if (take_i) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign out_o.done = (state_q == L_DONE);
  assign out_o.res  = res_q;

endmodule

### rtl/core/jacs_cal.sv
module jacs_cal #(
  parameter int AXES        = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   confirm_i,
  input  logic                   request_i,
  input  logic [SAMPLE_BITS-1:0] v_i   [AXES],
  output logic [SAMPLE_BITS-1:0] min_o [AXES],
  output logic [SAMPLE_BITS-1:0] mid_o [AXES],
  output logic [SAMPLE_BITS-1:0] max_o [AXES],
  output jacs_pkg::cal_stat_t    stat_o
);
  import jacs_pkg::*;

  typedef enum logic [1:0] {
    STEP_CENTRE = 2'd1,
    STEP_INIT   = 2'd2,
    STEP_TRACK  = 2'd3
  } cal_step_e;

  cal_step_e step_q;
  logic      active_q;
  logic      done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_CENTRE;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (step_i) begin
      done_q <= 1'b0;
      if (active_q) begin
        unique case (step_q)
          STEP_CENTRE: if (confirm_i) step_q <= STEP_INIT;
          STEP_INIT:   step_q <= STEP_TRACK;
          STEP_TRACK: begin
            if (confirm_i) begin
              step_q   <= STEP_CENTRE;
              active_q <= 1'b0;
              done_q   <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // a request restarts the sequence from the centre capture
      if (request_i) begin
        active_q <= 1'b1;
        step_q   <= STEP_CENTRE;
      end
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic [SAMPLE_BITS-1:0] min_q, mid_q, max_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        min_q <= RST_MIN[a % 4][SAMPLE_BITS-1:0];
        mid_q <= RST_MID[a % 4][SAMPLE_BITS-1:0];
        max_q <= RST_MAX[a % 4][SAMPLE_BITS-1:0];
      end else if (step_i && active_q) begin
        unique case (step_q)
          STEP_CENTRE: if (confirm_i) mid_q <= v_i[a];
          STEP_INIT: begin
            min_q <= mid_q;
            max_q <= '0;
          end
          STEP_TRACK: begin
            if (v_i[a] > max_q) max_q <= v_i[a];
            if (v_i[a] < min_q) min_q <= v_i[a];
          end
          default: ;
        endcase
      end
    end

    assign min_o[a] = min_q;
    assign mid_o[a] = mid_q;
    assign max_o[a] = max_q;
  end

  assign stat_o.phase = active_q ? 2'(step_q) : 2'd0;
  assign stat_o.done  = done_q;

endmodule

### rtl/core/jacs_merge.sv
module jacs_merge #(
  parameter int AXES  = 4,
  parameter int OUT_W = 40
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jacs_pkg::item_ctl_t ctl_i,
  input  jacs_pkg::lane_out_t lane_i [AXES],
  input  jacs_pkg::cal_stat_t cal_i,
  input  logic                m_axis_tready_i,
  output logic                m_axis_tvalid_o,
  output logic [OUT_W-1:0]    m_axis_tdata_o,
  output logic                m_axis_tuser_o,
  output logic                load_o
);
  import jacs_pkg::*;

  localparam int FIELD_W = AXES * OUT_BITS + 3;

  logic             all_done;
  logic [OUT_W-1:0] tdata_d;
  logic             tvalid_q;
  logic [OUT_W-1:0] tdata_q;
  logic             tuser_q;

  always_comb begin
    all_done = 1'b1;
    tdata_d  = '0;
    for (int a = 0; a < AXES; a++) begin
      all_done = all_done & lane_i[a].done;
      tdata_d[a*OUT_BITS +: OUT_BITS] = ctl_i.report ? lane_i[a].res : CENTRE_OUT;
    end
    tdata_d[AXES*OUT_BITS +: 2] = cal_i.phase;
    tdata_d[FIELD_W-1]          = cal_i.done;
  end

  // load once every lane has finished (or at once for a calibration word) and the output word is free
  assign load_o = ctl_i.pending && (!ctl_i.report || all_done) &&
                  (!tvalid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
      tdata_q  <= '0;
      tuser_q  <= 1'b0;
    end else if (load_o) begin
      tvalid_q <= 1'b1;
      tdata_q  <= tdata_d;
      tuser_q  <= ctl_i.report;
    end else if (m_axis_tready_i) begin
      tvalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

endmodule

### rtl/core/joystick_axis_calibrate_scale.sv
// Path: the input word is registered, then each axis lane steps through half, class,
// load, bit-serial divide and fix; a lane with a fixed value skips divide and fix.
// Flow: a new input word is taken only once the last one is loaded for output; the
// bit-serial divider in each lane sets the pace; calibration words bypass the lanes.
// Reset: asynchronous, active low; restores factory extents and register defaults.
module joystick_axis_calibrate_scale #(
  parameter int AXES        = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // raw axes (SAMPLE_BITS each, lx first), confirm_button, calibrate_request
  input  logic [((AXES*SAMPLE_BITS+2+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out axes (8 bits each, lx first), cal_phase, cal_done
  output logic [((AXES*8+3+7)/8)*8-1:0]   m_axis_tdata_o,
  // reporting
  output logic                            m_axis_tuser_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jacs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jacs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import jacs_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int OUT_W = ((AXES*8+3+7)/8)*8;

  // configuration registers
  logic [7:0] db_left_q, db_right_q;
  logic [7:0] early_q [4];
  logic [3:0] invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_left_q  <= RST_DEADBAND;
      db_right_q <= RST_DEADBAND;
      for (int k = 0; k < 4; k++) early_q[k] <= RST_EARLY;
      invert_q   <= RST_INVERT;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DB_LEFT:  db_left_q  <= cfg_data_i;
        CFG_DB_RIGHT: db_right_q <= cfg_data_i;
        CFG_EARLY_LX: early_q[0] <= cfg_data_i;
        CFG_EARLY_LY: early_q[1] <= cfg_data_i;
        CFG_EARLY_RX: early_q[2] <= cfg_data_i;
        CFG_EARLY_RY: early_q[3] <= cfg_data_i;
        CFG_INVERT:   invert_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input word capture
  logic          busy_q, go_q, report_q, confirm_q, request_q;
  logic [SB-1:0] v_q [AXES];
  logic          accept, load;
  cal_stat_t     cal_stat;
  item_ctl_t     ctl;

  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      go_q   <= 1'b0;
    end else begin
      go_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
    end
  end

  logic cal_active_n;
  assign cal_active_n = (cal_stat.phase == 2'd0);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      confirm_q <= s_axis_tdata_i[AXES*SB];
      request_q <= s_axis_tdata_i[AXES*SB+1];
      report_q  <= cal_active_n;
      for (int a = 0; a < AXES; a++) begin
        // inversion against full scale is a bitwise complement
        v_q[a] <= invert_q[a % 4] ? ~s_axis_tdata_i[a*SB +: SB]
                                  : s_axis_tdata_i[a*SB +: SB];
      end
    end
  end

  logic [SB-1:0] min_w [AXES];
  logic [SB-1:0] mid_w [AXES];
  logic [SB-1:0] max_w [AXES];

  jacs_cal #(
    .AXES       (AXES),
    .SAMPLE_BITS(SB)
  ) u_cal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (go_q),
    .confirm_i(confirm_q),
    .request_i(request_q),
    .v_i      (v_q),
    .min_o    (min_w),
    .mid_o    (mid_w),
    .max_o    (max_w),
    .stat_o   (cal_stat)
  );

  lane_out_t lane_out [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    jacs_lane #(
      .SAMPLE_BITS(SB)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(go_q && report_q),
      .take_i (load && report_q),
      .v_i    (v_q[a]),
      .min_i  (min_w[a]),
      .mid_i  (mid_w[a]),
      .max_i  (max_w[a]),
      .db_i   (a[1] ? db_right_q : db_left_q),
      .es_i   (early_q[a % 4]),
      .out_o  (lane_out[a])
    );
  end

  assign ctl.pending = busy_q && !go_q;
  assign ctl.report  = report_q;

  jacs_merge #(
    .AXES (AXES),
    .OUT_W(OUT_W)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .lane_i         (lane_out),
    .cal_i          (cal_stat),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .load_o         (load)
  );

endmodule

### rtl/core/jacs_checker.sv
module jacs_checker #(
  parameter int AXES = 4
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [((AXES*8+3+7)/8)*8-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o
);
  import jacs_pkg::*;

  localparam int PH = AXES * 8;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // one word in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a word is in flight");

  a_cal_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[7:0] == CENTRE_OUT)
    else $error("axis not centred while calibrating");

  a_done_not_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tdata_o[PH+2])
    else $error("calibration done flagged on a reporting word");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[PH+2] |->
      m_axis_tdata_o[PH+1:PH] == 2'd0 || m_axis_tdata_o[PH+1:PH] == 2'd1)
    else $error("calibration finished in a mid-sequence phase");

endmodule

bind joystick_axis_calibrate_scale jacs_checker #(
  .AXES(AXES)
) u_jacs_checker (.*);
